// ----- rtl/sas_pkg.sv -----
// Package for the sprite animation sequencer: opcodes, event kinds,
// command and event payload types, parameter defaults. No dependencies.
package sas_pkg;

    localparam int NUM_ANIMS_DEF  = 8;
    localparam int FRAME_BITS_DEF = 8;

    // command opcodes
    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_PLAY     = 3'd1;
    localparam logic [2:0] OP_STOP     = 3'd2;
    localparam logic [2:0] OP_STOP_NOW = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;

    // event kinds
    localparam logic [1:0] EV_SPRITE   = 2'd0;
    localparam logic [1:0] EV_FINISHED = 2'd1;
    localparam logic [1:0] EV_ADDED    = 2'd2;
    localparam logic [1:0] EV_REJECTED = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  anim_id;
        logic [31:0] now_ms;
        logic [7:0]  sheet_row;
        logic [7:0]  first_frame;
        logic [7:0]  last_frame;
        logic [15:0] frame_period;
        logic        repeat_flag;
        logic        start_now;
    } t_cmd;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [2:0] entry_id;
        logic [7:0] sprite_row;
        logic [7:0] sprite_frame;
    } t_evt;

endpackage

// ----- rtl/sas_if.sv -----
// Valid/ready channel interfaces for command and event transactions.
// Depends on sas_pkg.
interface sas_cmd_if;
    import sas_pkg::*;
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sas_evt_if;
    import sas_pkg::*;
    logic valid;
    logic ready;
    t_evt data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/sprite_animation_sequencer.sv -----
// Sprite animation sequencer top level: animation table, active animation
// state, command register and event register. Depends on sas_pkg, sas_if.
//
// Usage:
//   i_cmd carries one command per transaction (add, play, stop, stop now,
//   tick). o_evt returns at most one event per command: sprite select,
//   finished, added or rejected. Commands with no event (stop, ignored
//   play, idle stop now or tick, tick before the frame period, unused opcodes) just retire.
//   Flow: an accepted command is held in the command register, its table
//   entry read alongside, and is processed once the event register is free
//   or draining; its event is then held in the event register until taken.
//   Throughput: one command per cycle while o_evt is not stalled; the table
//   read and the single compare/increment pass are the whole per-command work.
//   The table has one write port (add) and one registered read port, which
//   looks ahead to the active entry the command ahead leaves behind, and
//   forwards an entry written in the same cycle.
//   Reset: empty table, nothing active, last tick time zero. Table contents
//   need no clearing, only entries below the fill count are ever used.
//   Receiver stall: the event register holds; the command register still
//   takes one more command, then i_cmd.ready drops until o_evt drains.
module sprite_animation_sequencer #(
    parameter int NUM_ANIMS  = sas_pkg::NUM_ANIMS_DEF,
    parameter int FRAME_BITS = sas_pkg::FRAME_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sas_cmd_if.sink       i_cmd,
    sas_evt_if.source     o_evt
);
    import sas_pkg::*;

    localparam int IDX_W  = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
    localparam int CNT_W  = $clog2(NUM_ANIMS + 1);
    localparam int FNOW_W = FRAME_BITS + 1;

    typedef struct packed {
        logic [7:0]            row;
        logic [FRAME_BITS-1:0] first_fr;
        logic [FRAME_BITS-1:0] last_fr;
        logic [15:0]           period;
        logic                  loops;
    } t_entry;

    // animation table, one write and one registered read per cycle
    t_entry r_table [NUM_ANIMS];
    t_entry r_rd_data;

    t_cmd r_req;
    logic r_req_vld;
    t_evt r_out;
    logic r_out_vld;

    logic [CNT_W-1:0]  r_entry_count, n_entry_count;
    logic              r_active_valid, n_active_valid;
    logic [IDX_W-1:0]  r_active_entry, n_active_entry;
    logic [FNOW_W-1:0] r_frame_now, n_frame_now;
    logic              r_running, n_running;
    logic [31:0]       r_last_tick, n_last_tick;

    t_evt n_evt;
    logic n_evt_vld;

    logic             in_fire;
    logic             proc_fire;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    t_entry           new_entry;

    logic              full;
    logic              id_loaded;
    logic              play_same;
    logic [31:0]       elapsed;
    logic              due;
    logic [FNOW_W-1:0] frame_inc;
    logic [FNOW_W-1:0] first_ext;
    logic              over;

    // ---- handshakes ----
    // processing retires the held command when the event slot is free
    // or being emptied this cycle
    assign proc_fire   = r_req_vld && (!r_out_vld || o_evt.ready);
    assign i_cmd.ready = !r_req_vld || proc_fire;
    assign in_fire     = i_cmd.valid && i_cmd.ready;
    assign o_evt.valid = r_out_vld;
    assign o_evt.data  = r_out;

    // ---- entry built from an add command ----
    assign new_entry.row      = r_req.sheet_row;
    assign new_entry.first_fr = FRAME_BITS'(r_req.first_frame);
    assign new_entry.last_fr  = FRAME_BITS'(r_req.last_frame);
    assign new_entry.period   = r_req.frame_period;
    assign new_entry.loops    = r_req.repeat_flag;
    assign wr_addr            = IDX_W'(r_entry_count);

    // ---- decode helpers ----
    assign full      = 32'(r_entry_count) >= 32'(NUM_ANIMS);
    assign id_loaded = 32'(r_req.anim_id) < 32'(r_entry_count);
    assign play_same = r_active_valid && (32'(r_active_entry) == 32'(r_req.anim_id));
    assign elapsed   = r_req.now_ms - r_last_tick;      // wraps mod 2^32
    assign due       = elapsed >= 32'(r_rd_data.period);
    assign frame_inc = r_frame_now + FNOW_W'(1);
    assign first_ext = FNOW_W'(r_rd_data.first_fr);
    assign over      = frame_inc > FNOW_W'(r_rd_data.last_fr);

    // ---- single processing pass ----
    always_comb begin
        n_entry_count  = r_entry_count;
        n_active_valid = r_active_valid;
        n_active_entry = r_active_entry;
        n_frame_now    = r_frame_now;
        n_running      = r_running;
        n_last_tick    = r_last_tick;
        n_evt          = '0;
        n_evt_vld      = 1'b0;
        wr_en          = 1'b0;
        if (proc_fire) begin
            case (r_req.opcode)
                OP_ADD: begin
                    n_evt_vld = 1'b1;
                    if (full) begin
                        n_evt.event_kind = EV_REJECTED;
                    end else begin
                        wr_en          = 1'b1;
                        n_entry_count  = r_entry_count + CNT_W'(1);
                        n_evt.event_kind = EV_ADDED;
                        n_evt.entry_id = 3'(r_entry_count);
                        if (r_req.start_now) begin
                            n_active_valid = 1'b1;
                            n_active_entry = wr_addr;
                            n_frame_now    = FNOW_W'(new_entry.first_fr);
                            n_running      = 1'b1;
                        end
                    end
                end
                OP_PLAY: begin
                    if (!play_same && id_loaded) begin
                        n_active_valid     = 1'b1;
                        n_active_entry     = IDX_W'(r_req.anim_id);
                        n_frame_now        = first_ext;
                        n_running          = 1'b1;
                        n_evt_vld          = 1'b1;
                        n_evt.event_kind   = EV_SPRITE;
                        n_evt.entry_id     = r_req.anim_id;
                        n_evt.sprite_row   = r_rd_data.row;
                        n_evt.sprite_frame = 8'(r_rd_data.first_fr);
                    end
                end
                OP_STOP: begin
                    if (r_active_valid) begin
                        n_running = 1'b0;
                    end
                end
                OP_STOP_NOW: begin
                    if (r_active_valid) begin
                        n_frame_now        = first_ext;
                        n_running          = 1'b0;
                        n_active_valid     = 1'b0;
                        n_evt_vld          = 1'b1;
                        n_evt.event_kind   = EV_SPRITE;
                        n_evt.entry_id     = 3'(r_active_entry);
                        n_evt.sprite_row   = r_rd_data.row;
                        n_evt.sprite_frame = 8'(r_rd_data.first_fr);
                    end
                end
                OP_TICK: begin
                    if (r_active_valid && due) begin
                        n_last_tick = r_req.now_ms;
                        n_frame_now = (over && r_rd_data.loops) ? first_ext : frame_inc;
                        n_evt_vld   = 1'b1;
                        n_evt.entry_id = 3'(r_active_entry);
                        // past the end and not looping on: the animation ends
                        if (over && (!r_rd_data.loops || !r_running)) begin
                            n_running        = 1'b0;
                            n_active_valid   = 1'b0;
                            n_evt.event_kind = EV_FINISHED;
                        end else begin
                            n_evt.event_kind   = EV_SPRITE;
                            n_evt.sprite_row   = r_rd_data.row;
                            n_evt.sprite_frame = 8'(n_frame_now);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // read ahead: play reads the named entry, everything else the entry
    // that will be active once the command ahead has retired
    assign rd_addr = (i_cmd.data.opcode == OP_PLAY) ? IDX_W'(i_cmd.data.anim_id)
                                                    : n_active_entry;

    // ---- table ----
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= new_entry;
        end
        if (in_fire) begin
            // forward an entry written in the same cycle
            if (wr_en && (wr_addr == rd_addr)) begin
                r_rd_data <= new_entry;
            end else begin
                r_rd_data <= r_table[rd_addr];
            end
        end
    end

    // ---- command and event registers ----
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req <= i_cmd.data;
        end
        if (proc_fire && n_evt_vld) begin
            r_out <= n_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld      <= 1'b0;
            r_out_vld      <= 1'b0;
            r_entry_count  <= '0;
            r_active_valid <= 1'b0;
            r_active_entry <= '0;
            r_frame_now    <= '0;
            r_running      <= 1'b0;
            r_last_tick    <= '0;
        end else begin
            if (in_fire) begin
                r_req_vld <= 1'b1;
            end else if (proc_fire) begin
                r_req_vld <= 1'b0;
            end
            if (proc_fire) begin
                r_out_vld <= n_evt_vld;
            end else if (o_evt.ready) begin
                r_out_vld <= 1'b0;
            end
            r_entry_count  <= n_entry_count;
            r_active_valid <= n_active_valid;
            r_active_entry <= n_active_entry;
            r_frame_now    <= n_frame_now;
            r_running      <= n_running;
            r_last_tick    <= n_last_tick;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_entry_count) <= 32'(NUM_ANIMS))
        else $error("entry count beyond table depth");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && (r_req.opcode == OP_ADD) && !full)
        |=> (r_entry_count == $past(r_entry_count) + CNT_W'(1)))
        else $error("accepted add did not grow the table");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && n_evt_vld && (n_evt.event_kind == EV_FINISHED))
        |=> !r_active_valid)
        else $error("finished event left the animation active");

    a_running_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> r_active_valid)
        else $error("running without an active animation");

    a_active_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active_valid |-> (32'(r_active_entry) < 32'(r_entry_count)))
        else $error("active entry not loaded");
`endif

endmodule
